// ===== hw/rtl/pedec_pkg.sv =====
package pedec_pkg;

    // Characters that the escape grammar looks at
    localparam logic [7:0] PCT_CHAR = 8'h25;
    localparam logic [7:0] DIG_0    = 8'h30;
    localparam logic [7:0] DIG_9    = 8'h39;
    localparam logic [7:0] HEX_A    = 8'h41;
    localparam logic [7:0] HEX_F    = 8'h46;

    // Ten, the value of the first letter digit
    localparam logic [7:0] HEX_TEN  = 8'd10;

    // Most result bytes one input byte can cause
    localparam int MAX_RES = 3;

    // Match progress of the escape recognizer
    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_PCT   = 3'b010,
        PH_DIGIT = 3'b100
    } phase_t;

    // Results caused by one input byte, handed from front to back
    typedef struct packed {
        logic [MAX_RES-1:0][7:0] bytes;
        logic [1:0]              cnt;
        logic                    last;
    } bundle_t;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= DIG_0) && (c <= DIG_9)) || ((c >= HEX_A) && (c <= HEX_F));
    endfunction

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] t;
        if (c <= DIG_9)
        begin
            t = c - DIG_0;
        end
        else
        begin
            t = c - HEX_A + HEX_TEN;
        end
        return t[3:0];
    endfunction

endpackage

// ===== hw/rtl/pedec_front.sv =====
module pedec_front
    import pedec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       raw_valid,
    output logic       raw_stall,
    input  logic [7:0] in_byte,
    input  logic       is_last,
    input  logic       q_full,
    output logic       q_push,
    output bundle_t    q_data
);

    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;
    logic       accept;

    // Hold input while the queue has no room
    assign raw_stall = q_full;
    assign accept    = raw_valid && !raw_stall;

    // Classify one byte and collect the results it causes
    always_comb
    begin
        logic [1:0] idx;
        logic       take_b;
        idx        = 2'd0;
        take_b     = 1'b0;
        phase_next = phase_reg;
        held_next  = held_reg;
        q_data     = '0;

        unique case (phase_reg)
            PH_PCT:
            begin
                if (is_hex(in_byte))
                begin
                    phase_next = PH_DIGIT;
                    held_next  = in_byte;
                end
                else
                begin
                    q_data.bytes[idx] = PCT_CHAR;
                    idx               = idx + 2'd1;
                    held_next         = '0;
                    take_b            = 1'b1;
                end
            end
            PH_DIGIT:
            begin
                if (is_hex(in_byte))
                begin
                    q_data.bytes[idx] = {nibble_of(held_reg), nibble_of(in_byte)};
                    idx               = idx + 2'd1;
                    phase_next        = PH_IDLE;
                end
                else
                begin
                    q_data.bytes[idx] = PCT_CHAR;
                    idx               = idx + 2'd1;
                    q_data.bytes[idx] = held_reg;
                    idx               = idx + 2'd1;
                    take_b            = 1'b1;
                end
                held_next = '0;
            end
            PH_IDLE:
            begin
                take_b = 1'b1;
            end
            default:
            begin
                take_b = 1'b1;
            end
        endcase

        // Examine the byte from idle, also again after a broken escape
        if (take_b)
        begin
            if (in_byte == PCT_CHAR)
            begin
                phase_next = PH_PCT;
            end
            else
            begin
                q_data.bytes[idx] = in_byte;
                idx               = idx + 2'd1;
                phase_next        = PH_IDLE;
            end
        end

        // Flush whatever is pending on the final byte
        if (is_last)
        begin
            if ((phase_next == PH_PCT) || (phase_next == PH_DIGIT))
            begin
                q_data.bytes[idx] = PCT_CHAR;
                idx               = idx + 2'd1;
            end
            if (phase_next == PH_DIGIT)
            begin
                q_data.bytes[idx] = held_next;
                idx               = idx + 2'd1;
            end
            phase_next = PH_IDLE;
            held_next  = '0;
        end

        q_data.cnt  = idx;
        q_data.last = is_last;
    end

    // Drop transfers that leave only pending state
    assign q_push = accept && (q_data.cnt != 2'd0);

    // Advance match state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

    a_held_only_in_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_DIGIT) |-> (held_reg == 8'h00))
        else $error("held digit left over outside digit phase");

    a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_last) |-> q_push)
        else $error("final byte produced no result");

endmodule

// ===== hw/rtl/pedec_queue.sv =====
module pedec_queue
    import pedec_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t push_data,
    input  logic    pop,
    output logic    full,
    output logic    not_empty,
    output bundle_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bundle_t            slots_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slots_reg[rd_ptr_reg];

    // Advance pointers with wrap at the last slot
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");

endmodule

// ===== hw/rtl/pedec_back.sv =====
module pedec_back
    import pedec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_not_empty,
    input  bundle_t    q_head,
    output logic       q_pop,
    output logic       dec_valid,
    input  logic       dec_stall,
    output logic [7:0] out_byte,
    output logic       run_end,
    output logic       stream_end
);

    bundle_t    cur_reg;
    logic [1:0] idx_reg;
    logic       busy_reg;
    logic       xfer;
    logic       at_end;

    assign dec_valid  = busy_reg;
    assign xfer       = busy_reg && !dec_stall;
    assign at_end     = (idx_reg == (cur_reg.cnt - 2'd1));
    assign out_byte   = cur_reg.bytes[idx_reg];
    assign run_end    = at_end;
    assign stream_end = at_end && cur_reg.last;

    // Load the next entry when idle or once the current one is fully sent
    assign q_pop = q_not_empty && (!busy_reg || (xfer && at_end));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (q_pop)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (xfer)
        begin
            if (at_end)
            begin
                busy_reg <= 1'b0;
                idx_reg  <= '0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    // Hold the entry being sent
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_head;
        end
    end

    a_busy_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> ((cur_reg.cnt != 2'd0) && (idx_reg < cur_reg.cnt)))
        else $error("back stage points past its entry");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (dec_valid && dec_stall) |=> (dec_valid && $stable(idx_reg)))
        else $error("output moved while stalled");

endmodule

// ===== hw/rtl/percent_escape_decoder_unit.sv =====
// Channel  Direction  Handshake              Payload
// raw      input      raw_valid / raw_stall  in_byte, is_last
// dec      output     dec_valid / dec_stall  out_byte, run_end, stream_end
//
// The front handles each input byte combinationally; a new byte can follow every cycle while raw_stall is low.
// The back sends one result byte per cycle while dec_stall is low, one to three per queued entry.
// Results are registered in a queue slot, then in the back's entry; QUEUE_DEPTH entries buffer.
// raw_stall follows queue full: the output side stalled, or queued entries hold
// more bytes than the back has sent so far.
// Reset clears match state, queue and back stage; no clearing pass.
module percent_escape_decoder_unit
    import pedec_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       raw_valid,
    output logic       raw_stall,
    input  logic [7:0] in_byte,
    input  logic       is_last,
    output logic       dec_valid,
    input  logic       dec_stall,
    output logic [7:0] out_byte,
    output logic       run_end,
    output logic       stream_end
);

    logic    q_push;
    logic    q_pop;
    logic    q_full;
    logic    q_not_empty;
    bundle_t q_in;
    bundle_t q_head;

    pedec_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .raw_valid (raw_valid),
        .raw_stall (raw_stall),
        .in_byte   (in_byte),
        .is_last   (is_last),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    pedec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    pedec_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .dec_valid   (dec_valid),
        .dec_stall   (dec_stall),
        .out_byte    (out_byte),
        .run_end     (run_end),
        .stream_end  (stream_end)
    );

endmodule
